/* sv/hctd_pkg.sv */
// shared types, codes and helpers for the chunked transfer decoder
package hctd_pkg;

  // width of the running total of chunk sizes
  localparam int unsigned TOTAL_W = 32;

  // byte codes seen in size lines
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // returned by hex_value for a byte that is not a hex digit
  localparam logic [4:0] HEX_NONE = 5'd16;

  // status codes on the result channel
  localparam logic [1:0] STAT_DECODING = 2'd0;
  localparam logic [1:0] STAT_DONE     = 2'd1;
  localparam logic [1:0] STAT_ERROR    = 2'd2;

  // parser phase, one-hot
  typedef enum logic [7:0] {
    PH_SIZE    = 8'b0000_0001,
    PH_EXT     = 8'b0000_0010,
    PH_SIZE_LF = 8'b0000_0100,
    PH_DATA    = 8'b0000_1000,
    PH_DATA_CR = 8'b0001_0000,
    PH_DATA_LF = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } phase_t;

  // one result item
  typedef struct packed {
    logic [7:0]         payload_byte;
    logic               payload_valid;
    logic [1:0]         status;
    logic [TOTAL_W-1:0] total_size;
  } result_t;

  // hex digit value 0..15, or HEX_NONE
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41 + 8'd10);
    end
    return v;
  endfunction

endpackage

/* sv/hctd_in_stage.sv */
// input register stage: holds one received byte until the parser takes it
module hctd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       adv,
  output logic       a_valid,
  output logic [7:0] a_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  // stall only while a held byte cannot move on
  assign in_stall  = valid_r && !adv;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload loads on a transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_data_byte;
    end
  end

  assign a_valid = valid_r;
  assign a_byte  = byte_r;

endmodule

/* sv/hctd_parse.sv */
// chunk framing state machine, size accumulation and running total
module hctd_parse #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  output hctd_pkg::result_t   res
);

  localparam int unsigned SumW = ((SIZE_BITS > hctd_pkg::TOTAL_W) ?
                                  SIZE_BITS : hctd_pkg::TOTAL_W) + 1;

  hctd_pkg::phase_t                phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]            accum_r, accum_nxt;
  logic [3:0]                      digits_r, digits_nxt;
  logic [SIZE_BITS-1:0]            left_r, left_nxt;
  logic [hctd_pkg::TOTAL_W-1:0]    total_r, total_nxt;

  logic [4:0]                      hv;
  logic [SumW-1:0]                 sum;
  logic [SIZE_BITS-1:0]            left_dec;
  logic [7:0]                      pbyte;
  logic                            pvalid;

  assign hv       = hctd_pkg::hex_value(data_byte);
  assign sum      = SumW'(total_r) + SumW'(accum_r);
  assign left_dec = (left_r != '0) ? (left_r - SIZE_BITS'(1)) : '0;

  // next state for one byte
  always_comb begin
    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    digits_nxt = digits_r;
    left_nxt   = left_r;
    total_nxt  = total_r;
    pbyte      = 8'd0;
    pvalid     = 1'b0;
    unique case (phase_r)
      hctd_pkg::PH_SIZE: begin
        if (hv != hctd_pkg::HEX_NONE) begin
          if (accum_r[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_nxt = hctd_pkg::PH_ERROR;
          end else begin
            accum_nxt = {accum_r[SIZE_BITS-5:0], hv[3:0]};
            if (digits_r != 4'd15) digits_nxt = digits_r + 4'd1;
          end
        end else if (digits_r == 4'd0) begin
          phase_nxt = hctd_pkg::PH_ERROR;
        end else if (data_byte == hctd_pkg::CH_SEMI) begin
          phase_nxt = hctd_pkg::PH_EXT;
        end else if (data_byte == hctd_pkg::CH_CR) begin
          phase_nxt = hctd_pkg::PH_SIZE_LF;
        end else begin
          phase_nxt = hctd_pkg::PH_ERROR;
        end
      end
      hctd_pkg::PH_EXT: begin
        if (data_byte == hctd_pkg::CH_CR) begin
          phase_nxt = hctd_pkg::PH_SIZE_LF;
        end else if (data_byte == hctd_pkg::CH_LF) begin
          phase_nxt = hctd_pkg::PH_ERROR;
        end
      end
      hctd_pkg::PH_SIZE_LF: begin
        if (data_byte != hctd_pkg::CH_LF) begin
          phase_nxt = hctd_pkg::PH_ERROR;
        end else if (accum_r == '0) begin
          phase_nxt = hctd_pkg::PH_DONE;
        end else begin
          // saturating add into the total
          if (sum[SumW-1:hctd_pkg::TOTAL_W] != '0) begin
            total_nxt = '1;
          end else begin
            total_nxt = sum[hctd_pkg::TOTAL_W-1:0];
          end
          left_nxt   = accum_r;
          accum_nxt  = '0;
          digits_nxt = 4'd0;
          phase_nxt  = hctd_pkg::PH_DATA;
        end
      end
      hctd_pkg::PH_DATA: begin
        pbyte    = data_byte;
        pvalid   = 1'b1;
        left_nxt = left_dec;
        if (left_dec == '0) phase_nxt = hctd_pkg::PH_DATA_CR;
      end
      hctd_pkg::PH_DATA_CR: begin
        phase_nxt = (data_byte == hctd_pkg::CH_CR) ? hctd_pkg::PH_DATA_LF
                                                   : hctd_pkg::PH_ERROR;
      end
      hctd_pkg::PH_DATA_LF: begin
        if (data_byte == hctd_pkg::CH_LF) begin
          phase_nxt  = hctd_pkg::PH_SIZE;
          accum_nxt  = '0;
          digits_nxt = 4'd0;
        end else begin
          phase_nxt = hctd_pkg::PH_ERROR;
        end
      end
      hctd_pkg::PH_DONE, hctd_pkg::PH_ERROR: begin
        // input ignored, everything held
      end
      default: begin
        phase_nxt = hctd_pkg::PH_ERROR;
      end
    endcase
  end

  // state registers advance once per byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= hctd_pkg::PH_SIZE;
      accum_r  <= '0;
      digits_r <= 4'd0;
      left_r   <= '0;
      total_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      accum_r  <= accum_nxt;
      digits_r <= digits_nxt;
      left_r   <= left_nxt;
      total_r  <= total_nxt;
    end
  end

  // result for the byte being stepped, status after the byte
  always_comb begin
    res.payload_byte  = pbyte;
    res.payload_valid = pvalid;
    res.total_size    = total_nxt;
    if (phase_nxt == hctd_pkg::PH_DONE) begin
      res.status = hctd_pkg::STAT_DONE;
    end else if (phase_nxt == hctd_pkg::PH_ERROR) begin
      res.status = hctd_pkg::STAT_ERROR;
    end else begin
      res.status = hctd_pkg::STAT_DECODING;
    end
  end

  // error is sticky until reset
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hctd_pkg::PH_ERROR) |=> (phase_r == hctd_pkg::PH_ERROR))
    else $error("error phase left without reset");

  // total never goes down
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (total_r >= $past(total_r)))
    else $error("running total decreased");

  // payload phase always has bytes left to pass
  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == hctd_pkg::PH_DATA) |-> (left_r != '0))
    else $error("payload phase with no bytes left");

endmodule

/* sv/http_chunked_transfer_decoder_top.sv */
// top level of the chunked transfer decoder: input stage, parser, result register
//
// Decodes an HTTP/1.1 chunked body arriving one byte per transfer on the
// in_ channel (in_valid, in_stall, in_data_byte). Every input byte gives
// exactly one result on the out_ channel: out_payload_byte/out_payload_valid
// carry the byte when it is chunk payload, out_status reports decoding,
// finished (zero-size chunk seen) or format error, and out_total_size the
// saturating sum of chunk sizes so far.
// A byte transferred on the in_ channel is registered in the input stage,
// then parsed and loaded into the result register, which offers its result.
// Throughput: one byte per cycle while out_stall is low; the parser does
// one small state update per byte between the input register and the
// result register.
// Reset (rst_n low, synchronous) returns the parser to the first size digit
// and clears the total and both valid flags.
// With a result offered and out_stall high the result register holds; one more
// byte waits in the input stage, after which in_stall rises in the same cycle.
module http_chunked_transfer_decoder_top #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_data_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_payload_byte,
  output logic                         out_payload_valid,
  output logic [1:0]                   out_status,
  output logic [hctd_pkg::TOTAL_W-1:0] out_total_size
);

  logic              adv;
  logic              a_valid;
  logic [7:0]        a_byte;
  logic              step;
  hctd_pkg::result_t res;
  hctd_pkg::result_t res_r;
  logic              out_valid_r, out_valid_nxt;

  // result slot is free when empty or being drained
  assign adv  = !out_valid_r || !out_stall;
  assign step = a_valid && adv;

  hctd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .adv          (adv),
    .a_valid      (a_valid),
    .a_byte       (a_byte)
  );

  hctd_parse #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (a_byte),
    .res       (res)
  );

  // result register
  assign out_valid_nxt = adv ? a_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = res_r.payload_byte;
  assign out_payload_valid = res_r.payload_valid;
  assign out_status        = res_r.status;
  assign out_total_size    = res_r.total_size;

  // a byte is only stalled when the input stage is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_valid)
    else $error("input stalled with empty input stage");

  // non-payload results carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_payload_valid) |-> (out_payload_byte == 8'd0))
    else $error("non-payload result with nonzero byte");

  // a stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(res_r)))
    else $error("stalled result changed");

endmodule
